// ===== hdl/ultrasonic_echo_ranger_core_assert.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger - assertion macros
// Shared property shorthands for the ranger checker, clocked on i_clk and
// held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// same-cycle implication
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger - package
// Transaction payload types, register map and fixed timing constants.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TMO_W   = 20;   // timeout register width
    localparam int MAXC_W  = 10;   // distance limit register width
    localparam int DIST_W  = 15;   // distance field width
    localparam int EL_W    = 21;   // elapsed tick counter width
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    // register index, taken from paddr[2]
    localparam logic REG_TIMEOUT_US      = 1'b0;
    localparam logic REG_MAX_DISTANCE_CM = 1'b1;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } t_ranger_in;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
        logic [DIST_W-1:0] last_distance_cm;
    } t_ranger_out;

endpackage

// ===== hdl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Trigger/echo range measurement, one microsecond tick per input transaction.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------
//  tick in  | input     | i_in_valid / o_in_stall    | i_in_data   (t_ranger_in)
//  result   | output    | o_out_valid / i_out_stall  | o_out_data  (t_ranger_out)
//  config   | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One tick transaction is taken every cycle while o_in_stall is low; each
//  gives exactly one result (input register, then result register).
//  A single pass of phase logic sits between the two registers; the distance
//  comes from a quotient/remainder counter that runs alongside the pulse
//  count, so no divider sits in that pass.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A stalled result holds in the result register while the input register
//  still takes one more tick; after that o_in_stall rises.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core
    import uer_pkg::*;
#(
    parameter int CM_DIVISOR         = 29,
    parameter int DEFAULT_TIMEOUT_US = 23200,
    parameter int DEFAULT_MAX_CM     = 400
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // tick transactions
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_ranger_in          i_in_data,
    // result transactions
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_ranger_out         o_out_data,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // one pulse centimetre is 2*CM_DIVISOR ticks of echo (there and back)
    localparam int PULSE_DIV = 2 * CM_DIVISOR;
    localparam int REM_W     = $clog2(PULSE_DIV);

    localparam logic [REM_W-1:0]  REM_LAST  = REM_W'(PULSE_DIV - 1);
    localparam logic [TMO_W-1:0]  DEF_TMO   = TMO_W'(DEFAULT_TIMEOUT_US);
    localparam logic [EL_W-1:0]   DEF_TMO_E = EL_W'(DEFAULT_TIMEOUT_US);
    localparam logic [MAXC_W-1:0] DEF_MAXC  = MAXC_W'(DEFAULT_MAX_CM);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TLOW  = 5'b00010,
        PH_THIGH = 5'b00100,
        PH_WAIT  = 5'b01000,
        PH_PULSE = 5'b10000
    } t_phase;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TMO_W-1:0]  r_timeout_us;
    logic [MAXC_W-1:0] r_max_cm;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us <= DEF_TMO;
            r_max_cm     <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TIMEOUT_US:      r_timeout_us <= pwdata[TMO_W-1:0];
                REG_MAX_DISTANCE_CM: r_max_cm     <= pwdata[MAXC_W-1:0];
                default:             r_timeout_us <= r_timeout_us;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT_US:      prdata = APB_DW'(r_timeout_us);
            REG_MAX_DISTANCE_CM: prdata = APB_DW'(r_max_cm);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and stage hand-off
    // ------------------------------------------------------------------
    logic        r_in_valid;
    t_ranger_in  r_in;
    logic        r_out_valid;
    t_ranger_out r_out;
    logic        adv;

    // advance the held tick whenever the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Measurement state
    // ------------------------------------------------------------------
    t_phase            r_phase,   n_phase;
    logic [EL_W-1:0]   r_elapsed, n_elapsed;
    logic [DIST_W-1:0] r_dq,      n_dq;      // echo ticks / PULSE_DIV
    logic [REM_W-1:0]  r_dr,      n_dr;      // echo ticks % PULSE_DIV
    logic [DIST_W-1:0] r_kept,    n_kept;
    t_ranger_out       n_out;

    logic [TMO_W-1:0]  eff_tmo;
    logic [EL_W-1:0]   elapsed_inc;
    logic [DIST_W-1:0] dq_inc;
    logic [REM_W-1:0]  dr_inc;
    logic [EL_W-1:0]   dur;
    logic [DIST_W-1:0] dur_q;
    logic [REM_W-1:0]  dur_r;
    logic [MAXC_W-1:0] lim;
    logic              cap_on;
    logic              over_cap;
    logic              range_kill;
    logic              pulse_done;

    assign eff_tmo     = (r_timeout_us != '0) ? r_timeout_us : DEF_TMO;
    assign elapsed_inc = r_elapsed + EL_W'(1);

    // step the quotient/remainder pair along with the echo count
    assign dr_inc = (r_dr == REM_LAST) ? '0 : r_dr + REM_W'(1);
    assign dq_inc = (r_dr == REM_LAST) ? r_dq + DIST_W'(1) : r_dq;

    // duration at the finishing tick: counted with this tick if echo still high
    assign dur   = r_in.echo_level ? elapsed_inc : r_elapsed;
    assign dur_q = r_in.echo_level ? dq_inc : r_dq;
    assign dur_r = r_in.echo_level ? dr_inc : r_dr;

    // duration cap is max_distance_cm * PULSE_DIV; compare through quotient
    assign lim      = (r_max_cm != '0) ? r_max_cm : DEF_MAXC;
    assign cap_on   = (r_max_cm != '0);
    assign over_cap = (dur_q > DIST_W'(r_max_cm)) ||
                      ((dur_q == DIST_W'(r_max_cm)) && (dur_r != '0));
    assign range_kill = (cap_on && over_cap && (dur > DEF_TMO_E)) ||
                        (dur_q > DIST_W'(lim));

    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_dq       = r_dq;
        n_dr       = r_dr;
        n_kept     = r_kept;
        pulse_done = 1'b0;

        n_out                  = '0;
        n_out.busy_res         = 1'b1;

        unique case (r_phase)
            PH_TLOW: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= EL_W'(TRIG_LOW_TICKS)) begin
                    n_phase   = PH_THIGH;
                    n_elapsed = '0;
                end
            end
            PH_THIGH: begin
                n_out.trigger_level = 1'b1;
                n_elapsed           = elapsed_inc;
                if (elapsed_inc >= EL_W'(TRIG_HIGH_TICKS)) begin
                    n_phase   = PH_WAIT;
                    n_elapsed = '0;
                end
            end
            PH_WAIT: begin
                // the tick that sees echo high is the first pulse tick
                if (r_in.echo_level) begin
                    n_phase   = PH_PULSE;
                    n_elapsed = EL_W'(1);
                    n_dq      = '0;
                    n_dr      = REM_W'(1);
                end else begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc > EL_W'(eff_tmo)) begin
                        n_phase   = PH_PULSE;
                        n_elapsed = '0;
                        n_dq      = '0;
                        n_dr      = '0;
                    end
                end
            end
            PH_PULSE: begin
                if (r_in.echo_level) begin
                    n_elapsed = elapsed_inc;
                    n_dq      = dq_inc;
                    n_dr      = dr_inc;
                    pulse_done = (elapsed_inc > EL_W'(eff_tmo));
                end else begin
                    pulse_done = 1'b1;
                end
                if (pulse_done) begin
                    n_out.done_res    = 1'b1;
                    n_out.distance_cm = range_kill ? '0 : dur_q;
                    n_kept            = n_out.distance_cm;
                    n_phase           = PH_IDLE;
                    n_elapsed         = '0;
                end
            end
            default: begin
                // idle, and any stray code falls back to idle
                n_phase = PH_IDLE;
                if (r_in.start_req) begin
                    n_phase   = PH_TLOW;
                    n_elapsed = EL_W'(1);
                end else begin
                    n_out.busy_res = 1'b0;
                    n_elapsed      = '0;
                end
            end
        endcase

        n_out.last_distance_cm = n_kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_kept    <= DIST_W'(1);
        end else if (adv) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_kept    <= n_kept;
        end
    end

    // quotient pair only matters inside a pulse, so no reset
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dq <= n_dq;
            r_dr <= n_dr;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/uer_checker.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger - port checker
// Watches the result channel of the ranger core and checks field coherence.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_core_assert.svh"

module uer_checker
    import uer_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_ranger_out o_out_data
);

    `UER_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    `UER_ASSERT_NOW(a_done_busy, o_out_valid && o_out_data.done_res, o_out_data.busy_res && !o_out_data.trigger_level, "done without busy or with trigger high")

    `UER_ASSERT_NOW(a_done_keeps, o_out_valid && o_out_data.done_res, o_out_data.last_distance_cm == o_out_data.distance_cm, "kept distance not updated on finish")

    `UER_ASSERT_NOW(a_idle_dist, o_out_valid && !o_out_data.done_res, o_out_data.distance_cm == '0, "distance shown outside finish")

    `UER_ASSERT_NOW(a_trig_busy, o_out_valid && o_out_data.trigger_level, o_out_data.busy_res, "trigger driven while idle")

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
